FILE: sv/indexed_list_buffer_macros.svh
// assertion macros for the indexed list buffer
// used by modules that sample on i_clk and hold off checks while i_rst_n is low
`ifndef INDEXED_LIST_BUFFER_MACROS_SVH
`define INDEXED_LIST_BUFFER_MACROS_SVH

// same-cycle implication
`define ILB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ILB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ilb_pkg.sv
// types and codes shared by the indexed list buffer modules
// no dependencies
`timescale 1ns / 1ps

package ilb_pkg;

    // widest index and data word that the parameter ranges allow
    localparam int IDX_MAX_W  = 10;
    localparam int WORD_MAX_W = 64;
    localparam int CMP_W      = IDX_MAX_W + 1;

    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_GET    = 3'd2,
        OP_SET    = 3'd3,
        OP_INSERT = 3'd4,
        OP_REMOVE = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        CO_HOLD,
        CO_WRITE,
        CO_INSERT,
        CO_REMOVE
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DONE
    } t_state;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_cell_op               op;
        logic [IDX_MAX_W-1:0]   idx;
        logic [WORD_MAX_W-1:0]  wdata;
        logic [IDX_MAX_W-1:0]   rsel;
    } t_cell_ctl;

endpackage

FILE: sv/ilb_cell.sv
// one storage cell of the list chain: holds an entry, shifts with its neighbors,
// and forwards the read path one cell per cycle; depends on ilb_pkg
`timescale 1ns / 1ps

module ilb_cell import ilb_pkg::*; #(
    parameter int IDX       = 0,
    parameter int WORD_BITS = 32
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [WORD_BITS-1:0] i_lower,
    input  logic [WORD_BITS-1:0] i_upper,
    input  logic [WORD_BITS-1:0] i_rd,
    output logic [WORD_BITS-1:0] o_data,
    output logic [WORD_BITS-1:0] o_rd
);

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;
    logic [WORD_BITS-1:0] r_rd;
    logic [WORD_BITS-1:0] n_rd;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CO_WRITE: begin
                if (i_ctl.idx == MY_IDX) n_data = i_ctl.wdata[WORD_BITS-1:0];
            end
            CO_INSERT: begin
                if (MY_IDX > i_ctl.idx) n_data = i_lower;
                else if (MY_IDX == i_ctl.idx) n_data = i_ctl.wdata[WORD_BITS-1:0];
            end
            CO_REMOVE: begin
                if (MY_IDX >= i_ctl.idx) n_data = i_upper;
            end
            default: n_data = r_data;
        endcase
        // selected cell injects its word, the rest pass the upper neighbor's beat down
        n_rd = (i_ctl.rsel == MY_IDX) ? r_data : i_rd;
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_rd   <= n_rd;
    end

    assign o_data = r_data;
    assign o_rd   = r_rd;

endmodule

FILE: sv/indexed_list_buffer.sv
// indexed list buffer: push, pop, get, set, insert and remove on a chain of cells.
// push, set, insert, remove and refused ops: result strobed in the cycle after accept, busy stays low.
// pop and get: busy through S_READ and S_DONE, and S_DONE loads the registered result and strobe; the read
//   walks down the cell chain one cell per cycle to cell 0.
// synchronous active-low reset empties the list; the receiver cannot stall results.
`timescale 1ns / 1ps
`include "indexed_list_buffer_macros.svh"

module indexed_list_buffer import ilb_pkg::*; #(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [POS_W-1:0]    i_position,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_strobe,
    output logic [VALUE_W-1:0]  o_read_value,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_count
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_fill, n_fill;
    logic [IDX_MAX_W-1:0]  r_rsel, n_rsel;
    logic [ADDR_W-1:0]     r_cnt, n_cnt;
    logic                  r_strobe, n_strobe;
    logic [VALUE_W-1:0]    r_read_value, n_read_value;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [COUNT_W-1:0]    r_count, n_count;

    t_cell_ctl             w_ctl;
    logic [WORD_BITS-1:0]  w_word_in;
    logic [VALUE_W-1:0]    w_rd_out;
    logic                  w_read_go;
    logic [WORD_BITS-1:0]  w_data [DEPTH];
    logic [WORD_BITS-1:0]  w_rd   [DEPTH+1];

    // value port to stored word width and back
    generate
        if (WORD_BITS <= VALUE_W) begin : g_in_narrow
            assign w_word_in = i_value[WORD_BITS-1:0];
        end else begin : g_in_wide
            assign w_word_in = WORD_BITS'(i_value);
        end
        if (WORD_BITS >= VALUE_W) begin : g_out_narrow
            assign w_rd_out = w_rd[0][VALUE_W-1:0];
        end else begin : g_out_wide
            assign w_rd_out = VALUE_W'(w_rd[0]);
        end
    endgenerate

    assign w_rd[DEPTH] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [WORD_BITS-1:0] w_lower;
            logic [WORD_BITS-1:0] w_upper;
            if (gi == 0) begin : g_first
                assign w_lower = '0;
            end else begin : g_mid_lo
                assign w_lower = w_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_upper = '0;
            end else begin : g_mid_hi
                assign w_upper = w_data[gi+1];
            end
            ilb_cell #(
                .IDX       (gi),
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_lower (w_lower),
                .i_upper (w_upper),
                .i_rd    (w_rd[gi+1]),
                .o_data  (w_data[gi]),
                .o_rd    (w_rd[gi])
            );
        end
    endgenerate

    always_comb begin
        logic [CMP_W-1:0] v_pos;
        logic [CMP_W-1:0] v_fill;
        logic [CMP_W-1:0] v_new_fill;

        v_pos        = CMP_W'(i_position);
        v_fill       = CMP_W'(r_fill);
        v_new_fill   = '0;
        n_state      = r_state;
        n_fill       = r_fill;
        n_rsel       = r_rsel;
        n_cnt        = r_cnt;
        n_strobe     = 1'b0;
        n_read_value = r_read_value;
        n_status     = r_status;
        n_count      = r_count;
        w_read_go    = 1'b0;
        w_ctl.op     = CO_HOLD;
        w_ctl.idx    = IDX_MAX_W'(i_position);
        w_ctl.wdata  = WORD_MAX_W'(w_word_in);
        w_ctl.rsel   = r_rsel;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_strobe     = 1'b1;
                    n_read_value = '0;
                    n_status     = ST_OK;
                    unique case (t_op'(i_op))
                        OP_PUSH: begin
                            if (v_fill >= CMP_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.op  = CO_WRITE;
                                w_ctl.idx = IDX_MAX_W'(r_fill);
                                n_fill    = r_fill + CNT_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (r_fill == '0) begin
                                n_status = ST_RANGE;
                            end else begin
                                w_read_go = 1'b1;
                                n_rsel    = IDX_MAX_W'(r_fill - CNT_W'(1));
                                n_fill    = r_fill - CNT_W'(1);
                            end
                        end
                        OP_GET: begin
                            if (v_pos >= v_fill) begin
                                n_status = ST_RANGE;
                            end else begin
                                w_read_go = 1'b1;
                                n_rsel    = IDX_MAX_W'(i_position);
                            end
                        end
                        OP_SET: begin
                            if (v_pos >= v_fill) n_status = ST_RANGE;
                            else w_ctl.op = CO_WRITE;
                        end
                        OP_INSERT: begin
                            if (v_pos > v_fill) begin
                                n_status = ST_RANGE;
                            end else if (v_fill >= CMP_W'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.op = CO_INSERT;
                                n_fill   = r_fill + CNT_W'(1);
                            end
                        end
                        OP_REMOVE: begin
                            if (v_pos >= v_fill) begin
                                n_status = ST_RANGE;
                            end else begin
                                w_ctl.op = CO_REMOVE;
                                n_fill   = r_fill - CNT_W'(1);
                            end
                        end
                        default: n_status = ST_RANGE;
                    endcase
                    v_new_fill = CMP_W'(n_fill);
                    n_count    = v_new_fill[COUNT_W-1:0];
                    // reads report after the chain has settled
                    if (w_read_go) begin
                        n_strobe = 1'b0;
                        n_state  = S_READ;
                        n_cnt    = ADDR_W'(DEPTH - 1);
                    end
                end
            end
            S_READ: begin
                n_cnt = r_cnt - ADDR_W'(1);
                if (r_cnt == '0) n_state = S_DONE;
            end
            S_DONE: begin
                n_strobe     = 1'b1;
                n_read_value = w_rd_out;
                n_status     = ST_OK;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsel       <= n_rsel;
        r_cnt        <= n_cnt;
        r_read_value <= n_read_value;
        r_status     <= n_status;
        r_count      <= n_count;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = r_count;

    `ILB_ASSERT_NOW(a_fill_cap, 1'b1, r_fill <= CNT_W'(DEPTH), "fill above capacity")
    `ILB_ASSERT_NEXT(a_quick_result, start && !busy && !w_read_go, o_strobe,
        "missing result beat after one-cycle op")
    `ILB_ASSERT_NOW(a_no_beat_in_read, r_state == S_READ || r_state == S_DONE, !o_strobe,
        "result beat while a read is in flight")
    `ILB_ASSERT_NEXT(a_read_holds_fill, r_state == S_READ, r_fill == $past(r_fill),
        "fill changed during a read")

endmodule
